// ===== design/grid_maze_dfs_generator_assert.svh =====
// ----------------------------------------------------------------------------
// maze generator assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_DFS_GENERATOR_ASSERT_SVH
`define GRID_MAZE_DFS_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GMD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("gmd check failed");

// next-cycle implication
`define GMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("gmd check failed");

`endif

// ===== design/gmd_pkg.sv =====
// ----------------------------------------------------------------------------
// gmd_pkg
// shared types and constants of the maze generator
// ----------------------------------------------------------------------------
`default_nettype none

package gmd_pkg;

    // fixed field widths
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_DATA_W = 6;
    localparam int COORD_IN_W = 5;
    localparam int LOOP_W     = 11;
    localparam int DOOR_BITS  = 4;

    // cell entry: {visited, door mask}
    localparam int CELL_W  = 5;
    localparam int VIS_BIT = 4;
    localparam logic [CELL_W-1:0] VIS_MASK  = 5'b10000;
    localparam logic [CELL_W-1:0] FULL_MASK = 5'b11111;

    localparam logic [DOOR_BITS-1:0] DOOR_N = 4'b0001;
    localparam logic [DOOR_BITS-1:0] DOOR_E = 4'b0010;
    localparam logic [DOOR_BITS-1:0] DOOR_S = 4'b0100;
    localparam logic [DOOR_BITS-1:0] DOOR_W = 4'b1000;

    // neighbor order of the search
    localparam logic [1:0] DIR_W = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_N = 2'd3;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ISSUE0,
        S_ISSUE1,
        S_DECIDE,
        S_POP,
        S_RDATA,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_rnd_ctl;

    // residues of the value the next step will produce
    typedef struct packed {
        logic [1:0] lo;
        logic [1:0] mod3;
    } t_rnd;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] mask;
        logic [CELL_W-1:0] data;
    } t_cell_wr;

endpackage

`default_nettype wire

// ===== design/gmd_cell_ram.sv =====
// ----------------------------------------------------------------------------
// gmd_cell_ram
// cell store: visited flag and door mask per cell, bit-masked write port,
// two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module gmd_cell_ram #(
    parameter int AW = 10
) (
    input  wire logic                       i_clk,
    input  wire gmd_pkg::t_cell_wr          i_wr,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [AW-1:0]              i_raddr_a,
    input  wire logic [AW-1:0]              i_raddr_b,
    output logic [gmd_pkg::CELL_W-1:0]      o_rdata_a,
    output logic [gmd_pkg::CELL_W-1:0]      o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [gmd_pkg::CELL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < gmd_pkg::CELL_W; b++) begin
            if (i_wr.we && i_wr.mask[b]) begin
                r_mem[i_waddr][b] <= i_wr.data[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/gmd_stack_ram.sv =====
// ----------------------------------------------------------------------------
// gmd_stack_ram
// path stack store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gmd_stack_ram #(
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [AW-1:0]      o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [AW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/gmd_rng.sv =====
// ----------------------------------------------------------------------------
// gmd_rng
// 32-bit galois lfsr with the residues of its next value kept ready
// ----------------------------------------------------------------------------
`default_nettype none

module gmd_rng (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gmd_pkg::t_rnd_ctl i_ctl,
    input  wire logic [31:0]       i_seed,
    output gmd_pkg::t_rnd          o_rnd
);

    logic [31:0]   r_state;
    logic [31:0]   n_state;
    logic [31:0]   w_after;
    gmd_pkg::t_rnd r_rnd;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        return (v >> 1) ^ (v[0] ? gmd_pkg::LFSR_TAPS : 32'd0);
    endfunction

    // 4 = 1 mod 3, so two-bit digits are summed and folded
    function automatic logic [1:0] mod3(input logic [31:0] v);
        logic [3:0] grp [4];
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        for (int g = 0; g < 4; g++) begin
            grp[g] = 4'(v[8*g +: 2]) + 4'(v[8*g+2 +: 2])
                   + 4'(v[8*g+4 +: 2]) + 4'(v[8*g+6 +: 2]);
        end
        s1 = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]);
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
        s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    always_comb begin
        n_state = r_state;
        if (i_ctl.load) begin
            n_state = (i_seed == 32'd0) ? 32'd1 : i_seed;
        end else if (i_ctl.step) begin
            n_state = lfsr_step(r_state);
        end
        w_after = lfsr_step(n_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 32'd1;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd.lo   <= w_after[1:0];
        r_rnd.mod3 <= mod3(w_after);
    end

    assign o_rnd = r_rnd;

endmodule

`default_nettype wire

// ===== design/grid_maze_dfs_generator.sv =====
// ----------------------------------------------------------------------------
// grid_maze_dfs_generator
// perfect maze builder by randomized depth-first search over a cell store
// ----------------------------------------------------------------------------
// Items enter on the s_ stream (tuser = operation, tdata = cell_x, cell_y,
// seed) and one result per item leaves on the m_ stream (tuser = status,
// tdata = door_mask, open_doors, step_count). Grid width and height are set
// through the cfg write channel, which is always ready; write it only while
// the block is idle.
// An out-of-range item goes from IDLE straight to FINISH, a read passes
// through RDATA first. A generate first sweeps all 4^clog2(MAX_SIDE) entries
// of the cell store (1024 at the default), one entry a cycle, then runs
// 2 * width * height - 1 search iterations, each through ISSUE0 or POP, then
// ISSUE1 and DECIDE. The iteration rate is set by the two read ports of
// the cell store: four neighbor lookups per iteration.
// After reset the same sweep runs and s_tready stays low until it ends.
// One item is worked on at a time. A finished result waits in the output
// register while the receiver stalls; the next item is accepted meanwhile
// and its result is held until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_maze_dfs_generator_assert.svh"

module grid_maze_dfs_generator #(
    parameter int MAX_SIDE = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [gmd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [4:0] cell_x, [9:5] cell_y, [41:10] seed, rest zero
    input  wire logic [gmd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [0] operation
    input  wire logic                              i_s_tuser,
    // result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [3:0] door_mask, [6:4] open_doors, [17:7] step_count, rest zero
    output logic [gmd_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // [0] status
    output logic                                   o_m_tuser
);

    localparam int XW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * XW;
    localparam int DEPTH = 1 << AW;
    localparam int SDW   = $clog2(DEPTH + 1);

    gmd_pkg::t_state r_state;
    gmd_pkg::t_state n_state;

    logic [gmd_pkg::CFG_DATA_W-1:0] r_grid_w;
    logic [gmd_pkg::CFG_DATA_W-1:0] r_grid_h;
    logic [gmd_pkg::CFG_DATA_W-1:0] w_w;
    logic [gmd_pkg::CFG_DATA_W-1:0] w_h;

    logic                           w_op;
    logic [gmd_pkg::COORD_IN_W-1:0] w_in_x;
    logic [gmd_pkg::COORD_IN_W-1:0] w_in_y;
    logic [31:0]                    w_seed;
    logic                           w_s_acc;
    logic                           w_range_err;
    logic                           w_out_free;

    logic [AW-1:0]            r_clr_addr;
    logic                     r_clr_gen;
    logic [SDW-1:0]           r_depth;
    logic [SDW-1:0]           w_pop_idx;
    logic [gmd_pkg::LOOP_W-1:0] r_loop;
    logic [XW-1:0]            r_cur_x;
    logic [XW-1:0]            r_cur_y;
    logic                     r_vis_w;
    logic                     r_vis_e;
    logic                     r_pw_valid;
    logic [AW-1:0]            r_pw_addr;
    logic [gmd_pkg::DOOR_BITS-1:0] r_pw_door;

    logic                          r_res_status;
    logic [gmd_pkg::DOOR_BITS-1:0] r_res_door;

    logic                          r_out_valid;
    logic                          r_out_status;
    logic [gmd_pkg::DOOR_BITS-1:0] r_out_door;
    logic [2:0]                    r_out_open;
    logic [gmd_pkg::LOOP_W-1:0]    r_out_step;

    // search datapath
    logic [3:0]                    w_ok;
    logic [3:0]                    w_avail;
    logic [2:0]                    w_cnt;
    logic [1:0]                    w_k;
    logic [1:0]                    w_sel;
    logic [XW-1:0]                 w_nxt_x;
    logic [XW-1:0]                 w_nxt_y;
    logic [gmd_pkg::DOOR_BITS-1:0] w_here;
    logic [gmd_pkg::DOOR_BITS-1:0] w_there;
    logic [AW-1:0]                 w_cur_addr;
    logic [XW-1:0]                 w_pop_x;
    logic [XW-1:0]                 w_pop_y;

    // memory ports
    gmd_pkg::t_cell_wr          w_cell_wr;
    logic [AW-1:0]              w_cell_waddr;
    logic [AW-1:0]              w_cell_raddr_a;
    logic [AW-1:0]              w_cell_raddr_b;
    logic [gmd_pkg::CELL_W-1:0] w_cell_rdata_a;
    logic [gmd_pkg::CELL_W-1:0] w_cell_rdata_b;
    logic                       w_stk_we;
    logic [AW-1:0]              w_stk_waddr;
    logic [AW-1:0]              w_stk_wdata;
    logic [AW-1:0]              w_stk_raddr;
    logic [AW-1:0]              w_stk_rdata;

    gmd_pkg::t_rnd_ctl w_rnd_ctl;
    gmd_pkg::t_rnd     w_rnd;

    function automatic logic [gmd_pkg::CFG_DATA_W-1:0] eff_side(
        input logic [gmd_pkg::CFG_DATA_W-1:0] v
    );
        if (v == '0) begin
            return gmd_pkg::CFG_DATA_W'(1);
        end else if (int'(v) > MAX_SIDE) begin
            return gmd_pkg::CFG_DATA_W'(MAX_SIDE);
        end
        return v;
    endfunction

    function automatic logic [2:0] door_count(input logic [gmd_pkg::DOOR_BITS-1:0] m);
        return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    assign w_op   = i_s_tuser;
    assign w_in_x = i_s_tdata[4:0];
    assign w_in_y = i_s_tdata[9:5];
    assign w_seed = i_s_tdata[41:10];

    assign w_w = eff_side(r_grid_w);
    assign w_h = eff_side(r_grid_h);

    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_range_err = (gmd_pkg::CFG_DATA_W'(w_in_x) >= w_w)
                      || (gmd_pkg::CFG_DATA_W'(w_in_y) >= w_h);
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign w_cur_addr = {r_cur_y, r_cur_x};
    assign w_pop_x    = w_stk_rdata[XW-1:0];
    assign w_pop_y    = w_stk_rdata[AW-1:XW];
    assign w_pop_idx  = r_depth - SDW'(2);

    // neighbor bounds and candidates, in search order
    always_comb begin
        w_ok[gmd_pkg::DIR_W] = (r_cur_x != '0);
        w_ok[gmd_pkg::DIR_E] = (int'(r_cur_x) + 1) < int'(w_w);
        w_ok[gmd_pkg::DIR_S] = (r_cur_y != '0);
        w_ok[gmd_pkg::DIR_N] = (int'(r_cur_y) + 1) < int'(w_h);
        w_avail[gmd_pkg::DIR_W] = w_ok[gmd_pkg::DIR_W] && !r_vis_w;
        w_avail[gmd_pkg::DIR_E] = w_ok[gmd_pkg::DIR_E] && !r_vis_e;
        w_avail[gmd_pkg::DIR_S] = w_ok[gmd_pkg::DIR_S] && !w_cell_rdata_a[gmd_pkg::VIS_BIT];
        w_avail[gmd_pkg::DIR_N] = w_ok[gmd_pkg::DIR_N] && !w_cell_rdata_b[gmd_pkg::VIS_BIT];
        w_cnt = 3'(w_avail[0]) + 3'(w_avail[1]) + 3'(w_avail[2]) + 3'(w_avail[3]);
    end

    always_comb begin
        case (w_cnt)
            3'd2:    w_k = {1'b0, w_rnd.lo[0]};
            3'd3:    w_k = w_rnd.mod3;
            3'd4:    w_k = w_rnd.lo;
            default: w_k = 2'd0;
        endcase
    end

    // k-th available neighbor
    always_comb begin
        logic [2:0] v_seen;
        v_seen = 3'd0;
        w_sel  = gmd_pkg::DIR_W;
        for (int d = 0; d < 4; d++) begin
            if (w_avail[d]) begin
                if (v_seen == {1'b0, w_k}) begin
                    w_sel = 2'(d);
                end
                v_seen = v_seen + 3'd1;
            end
        end
    end

    always_comb begin
        w_nxt_x = r_cur_x;
        w_nxt_y = r_cur_y;
        case (w_sel)
            gmd_pkg::DIR_W: begin
                w_nxt_x = r_cur_x - XW'(1);
                w_here  = gmd_pkg::DOOR_W;
                w_there = gmd_pkg::DOOR_E;
            end
            gmd_pkg::DIR_E: begin
                w_nxt_x = r_cur_x + XW'(1);
                w_here  = gmd_pkg::DOOR_E;
                w_there = gmd_pkg::DOOR_W;
            end
            gmd_pkg::DIR_S: begin
                w_nxt_y = r_cur_y - XW'(1);
                w_here  = gmd_pkg::DOOR_S;
                w_there = gmd_pkg::DOOR_N;
            end
            default: begin
                w_nxt_y = r_cur_y + XW'(1);
                w_here  = gmd_pkg::DOOR_N;
                w_there = gmd_pkg::DOOR_S;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gmd_pkg::S_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = r_clr_gen ? gmd_pkg::S_INIT : gmd_pkg::S_IDLE;
                end
            end
            gmd_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    if (w_range_err) begin
                        n_state = gmd_pkg::S_FINISH;
                    end else if (w_op == gmd_pkg::OP_READ) begin
                        n_state = gmd_pkg::S_RDATA;
                    end else begin
                        n_state = gmd_pkg::S_CLEAR;
                    end
                end
            end
            gmd_pkg::S_INIT:   n_state = gmd_pkg::S_ISSUE0;
            gmd_pkg::S_ISSUE0: n_state = gmd_pkg::S_ISSUE1;
            gmd_pkg::S_ISSUE1: n_state = gmd_pkg::S_DECIDE;
            gmd_pkg::S_DECIDE: begin
                if (w_cnt != 3'd0) begin
                    n_state = gmd_pkg::S_ISSUE0;
                end else if (r_depth == SDW'(1)) begin
                    n_state = gmd_pkg::S_FINISH;
                end else begin
                    n_state = gmd_pkg::S_POP;
                end
            end
            gmd_pkg::S_POP:   n_state = gmd_pkg::S_ISSUE1;
            gmd_pkg::S_RDATA: n_state = gmd_pkg::S_FINISH;
            gmd_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = gmd_pkg::S_IDLE;
                end
            end
            default: n_state = gmd_pkg::S_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        o_s_tready     = 1'b0;
        w_cell_wr      = '0;
        w_cell_waddr   = w_cur_addr;
        w_cell_raddr_a = w_cur_addr;
        w_cell_raddr_b = w_cur_addr;
        w_stk_we       = 1'b0;
        w_stk_waddr    = r_depth[AW-1:0];
        w_stk_wdata    = {w_nxt_y, w_nxt_x};
        w_stk_raddr    = w_pop_idx[AW-1:0];
        w_rnd_ctl      = '0;
        case (r_state)
            gmd_pkg::S_CLEAR: begin
                w_cell_wr.we   = 1'b1;
                w_cell_wr.mask = gmd_pkg::FULL_MASK;
                w_cell_waddr   = r_clr_addr;
            end
            gmd_pkg::S_IDLE: begin
                o_s_tready     = 1'b1;
                w_cell_raddr_a = {XW'(w_in_y), XW'(w_in_x)};
                w_rnd_ctl.load = w_s_acc && !w_range_err && (w_op == gmd_pkg::OP_GENERATE);
            end
            gmd_pkg::S_INIT: begin
                w_cell_wr.we   = 1'b1;
                w_cell_wr.mask = gmd_pkg::VIS_MASK;
                w_cell_wr.data = gmd_pkg::VIS_MASK;
                w_stk_we       = 1'b1;
                w_stk_waddr    = '0;
                w_stk_wdata    = w_cur_addr;
            end
            gmd_pkg::S_ISSUE0: begin
                // door bit of the previous cell lands here, in the cycle after its push
                w_cell_wr.we   = r_pw_valid;
                w_cell_wr.mask = {1'b0, r_pw_door};
                w_cell_wr.data = {1'b0, r_pw_door};
                w_cell_waddr   = r_pw_addr;
                w_cell_raddr_a = {r_cur_y, r_cur_x - XW'(1)};
                w_cell_raddr_b = {r_cur_y, r_cur_x + XW'(1)};
            end
            gmd_pkg::S_ISSUE1: begin
                w_cell_raddr_a = {r_cur_y - XW'(1), r_cur_x};
                w_cell_raddr_b = {r_cur_y + XW'(1), r_cur_x};
            end
            gmd_pkg::S_DECIDE: begin
                if (w_cnt != 3'd0) begin
                    w_cell_wr.we   = 1'b1;
                    w_cell_wr.mask = gmd_pkg::FULL_MASK;
                    w_cell_wr.data = {1'b1, w_there};
                    w_cell_waddr   = {w_nxt_y, w_nxt_x};
                    w_stk_we       = 1'b1;
                    w_rnd_ctl.step = 1'b1;
                end
            end
            gmd_pkg::S_POP: begin
                // popped cell comes straight from the stack read port
                w_cell_raddr_a = {w_pop_y, w_pop_x - XW'(1)};
                w_cell_raddr_b = {w_pop_y, w_pop_x + XW'(1)};
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gmd_pkg::S_CLEAR;
            r_grid_w    <= gmd_pkg::CFG_DATA_W'(32);
            r_grid_h    <= gmd_pkg::CFG_DATA_W'(32);
            r_clr_addr  <= '0;
            r_clr_gen   <= 1'b0;
            r_depth     <= '0;
            r_loop      <= '0;
            r_pw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gmd_pkg::CFG_IDX_WIDTH:  r_grid_w <= i_cfg_data;
                    gmd_pkg::CFG_IDX_HEIGHT: r_grid_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                gmd_pkg::S_CLEAR: r_clr_addr <= r_clr_addr + AW'(1);
                gmd_pkg::S_IDLE: begin
                    if (w_s_acc && !w_range_err && (w_op == gmd_pkg::OP_GENERATE)) begin
                        r_clr_gen <= 1'b1;
                    end
                end
                gmd_pkg::S_INIT: begin
                    r_clr_gen <= 1'b0;
                    r_depth   <= SDW'(1);
                    r_loop    <= '0;
                end
                gmd_pkg::S_ISSUE0: r_pw_valid <= 1'b0;
                gmd_pkg::S_DECIDE: begin
                    r_loop <= r_loop + gmd_pkg::LOOP_W'(1);
                    if (w_cnt != 3'd0) begin
                        r_depth    <= r_depth + SDW'(1);
                        r_pw_valid <= 1'b1;
                    end else begin
                        r_depth <= r_depth - SDW'(1);
                    end
                end
                default: begin
                end
            endcase
            if ((r_state == gmd_pkg::S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            gmd_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    r_cur_x      <= XW'(w_in_x);
                    r_cur_y      <= XW'(w_in_y);
                    r_res_status <= w_range_err ? gmd_pkg::STATUS_RANGE : gmd_pkg::STATUS_OK;
                    r_res_door   <= '0;
                end
            end
            gmd_pkg::S_RDATA: r_res_door <= w_cell_rdata_a[gmd_pkg::DOOR_BITS-1:0];
            gmd_pkg::S_ISSUE1: begin
                r_vis_w <= w_cell_rdata_a[gmd_pkg::VIS_BIT];
                r_vis_e <= w_cell_rdata_b[gmd_pkg::VIS_BIT];
            end
            gmd_pkg::S_DECIDE: begin
                if (w_cnt != 3'd0) begin
                    r_cur_x   <= w_nxt_x;
                    r_cur_y   <= w_nxt_y;
                    r_pw_addr <= w_cur_addr;
                    r_pw_door <= w_here;
                end
            end
            gmd_pkg::S_POP: begin
                r_cur_x <= w_pop_x;
                r_cur_y <= w_pop_y;
            end
            default: begin
            end
        endcase
        if ((r_state == gmd_pkg::S_FINISH) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_door   <= r_res_door;
            r_out_open   <= door_count(r_res_door);
            r_out_step   <= r_loop;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {6'd0, r_out_step, r_out_open, r_out_door};

    gmd_cell_ram #(
        .AW (AW)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr      (w_cell_wr),
        .i_waddr   (w_cell_waddr),
        .i_raddr_a (w_cell_raddr_a),
        .i_raddr_b (w_cell_raddr_b),
        .o_rdata_a (w_cell_rdata_a),
        .o_rdata_b (w_cell_rdata_b)
    );

    gmd_stack_ram #(
        .AW (AW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    gmd_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rnd_ctl),
        .i_seed  (w_seed),
        .o_rnd   (w_rnd)
    );

    // pending door write lives only for the cycle after a push
    `GMD_ASSERT_IMPL(a_pend_only_issue0, r_pw_valid, r_state == gmd_pkg::S_ISSUE0)
    // a push always goes to a free neighbor
    `GMD_ASSERT_IMPL(a_push_is_free, (r_state == gmd_pkg::S_DECIDE) && (w_cnt != 3'd0), w_avail[w_sel])
    // a pop never runs on an empty stack
    `GMD_ASSERT_IMPL(a_pop_not_empty, r_state == gmd_pkg::S_POP, r_depth != '0)
    // a finished item reaches the output register
    `GMD_ASSERT_NEXT(a_finish_loads, (r_state == gmd_pkg::S_FINISH) && w_out_free, o_m_tvalid)

endmodule

`default_nettype wire
